[rtl/core/stt_pkg.sv]
// Shared types, token codes and lookup functions of the source text tokenizer.
// No dependencies; stt_front, stt_back and the top level import this package.
`default_nettype none
package stt_pkg;

	localparam logic [5:0] TK_EQ2    = 6'd3;
	localparam logic [5:0] TK_NE     = 6'd4;
	localparam logic [5:0] TK_GT     = 6'd5;
	localparam logic [5:0] TK_LT     = 6'd6;
	localparam logic [5:0] TK_GE     = 6'd7;
	localparam logic [5:0] TK_LE     = 6'd8;
	localparam logic [5:0] TK_MINUS  = 6'd10;
	localparam logic [5:0] TK_DIV    = 6'd12;
	localparam logic [5:0] TK_ASSIGN = 6'd14;
	localparam logic [5:0] TK_COLON  = 6'd16;
	localparam logic [5:0] TK_SEMI   = 6'd17;
	localparam logic [5:0] TK_TAG0   = 6'd36;
	localparam logic [5:0] TK_ID     = 6'd45;
	localparam logic [5:0] TK_INT    = 6'd46;
	localparam logic [5:0] TK_FLOAT  = 6'd47;
	localparam logic [5:0] TK_STR    = 6'd48;
	localparam logic [5:0] TK_EOL    = 6'd49;
	localparam logic [5:0] TK_END    = 6'd50;
	localparam logic [5:0] TK_NONE   = 6'd0;

	localparam logic [2:0] ST_TOKEN    = 3'd0;
	localparam logic [2:0] ST_BADFLOAT = 3'd1;
	localparam logic [2:0] ST_OPENSTR  = 3'd2;
	localparam logic [2:0] ST_OPENCMT  = 3'd3;
	localparam logic [2:0] ST_UNKNOWN  = 3'd4;
	localparam logic [2:0] ST_DONE     = 3'd5;

	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	typedef enum logic [3:0] {
		MD_BLANK, MD_MINUS, MD_SLASH, MD_LT, MD_GT, MD_EQ, MD_COLON, MD_INT,
		MD_DOT, MD_FRAC, MD_STRING, MD_IDENT, MD_SLC, MD_MLC, MD_MLC_STAR
	} mode_t;

	typedef enum logic [3:0] {
		CL_OTHER, CL_BLANK, CL_NL, CL_DIGIT, CL_ALPHA, CL_SINGLE, CL_SLASH,
		CL_MINUS, CL_LT, CL_GT, CL_EQ, CL_COLON, CL_QUOTE
	} cls_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_marker;
		cls_t       cls;
	} item_t;

	// front to back queue head
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	localparam int NUM_KW = 19;
	localparam logic [63:0] KW_TEXT [NUM_KW] = '{
		64'h746f6e, 64'h646e61, 64'h726f, 64'h646f6d, 64'h646e65,
		64'h6669, 64'h6e656874, 64'h666965736c65, 64'h65736c65, 64'h726f66,
		64'h6f74, 64'h70657473, 64'h6f64, 64'h656c696877, 64'h6e7275746572,
		64'h6e6f6974636e7566, 64'h6c6c756e, 64'h65757274, 64'h65736c6166
	};
	localparam logic [5:0] KW_CODE [NUM_KW] = '{
		6'd0, 6'd1, 6'd2, 6'd13, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
		6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd42, 6'd43, 6'd44
	};

	localparam int NUM_TAG = 6;
	localparam logic [63:0] TAG_TEXT [NUM_TAG] = '{
		64'h746e49, 64'h74616f6c46, 64'h676e69727453, 64'h7473694c,
		64'h74636944, 64'h776152
	};
	localparam logic [2:0] TAG_LEN [NUM_TAG] = '{
		3'd3, 3'd5, 3'd6, 3'd4, 3'd4, 3'd3
	};

	function automatic cls_t char_class(input logic [7:0] c);
		cls_t r;
		r = CL_OTHER;
		if (c == 8'h20 || c == 8'h09) r = CL_BLANK;
		else if (c == CH_NL) r = CL_NL;
		else if (c >= 8'h30 && c <= 8'h39) r = CL_DIGIT;
		else if (c == 8'h5f || (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a))
			r = CL_ALPHA;
		else if (c == CH_SLASH) r = CL_SLASH;
		else if (c == 8'h2d) r = CL_MINUS;
		else if (c == 8'h3c) r = CL_LT;
		else if (c == CH_GT) r = CL_GT;
		else if (c == CH_EQ) r = CL_EQ;
		else if (c == 8'h3a) r = CL_COLON;
		else if (c == CH_QUOTE) r = CL_QUOTE;
		else if (c == 8'h2b || c == CH_STAR || c == 8'h2c || c == 8'h3b || c == 8'h28 ||
			c == 8'h29 || c == 8'h5b || c == 8'h5d || c == 8'h7b || c == 8'h7d)
			r = CL_SINGLE;
		return r;
	endfunction

	function automatic logic [5:0] single_code(input logic [7:0] c);
		logic [5:0] r;
		case (c)
			8'h2b: r = 6'd9;
			8'h2a: r = 6'd11;
			8'h2c: r = 6'd15;
			8'h3b: r = 6'd17;
			8'h28: r = 6'd18;
			8'h29: r = 6'd19;
			8'h5b: r = 6'd20;
			8'h5d: r = 6'd21;
			8'h7b: r = 6'd22;
			8'h7d: r = 6'd23;
			default: r = TK_NONE;
		endcase
		return r;
	endfunction

	// keyword code, or identifier when the prefix matches none
	function automatic logic [5:0] kw_lookup(input logic [63:0] prefix);
		logic [5:0] r;
		r = TK_ID;
		for (int i = 0; i < NUM_KW; i++)
			if (KW_TEXT[i] == prefix) r = KW_CODE[i];
		return r;
	endfunction

	// {hit, complete, tag index} for letter c at place k after ':'
	function automatic logic [4:0] tag_match(input logic [2:0] k, input logic [55:0] la,
		input logic [7:0] c);
		logic [63:0] mask;
		logic [4:0]  r;
		mask = (64'h1 << {k, 3'b000}) - 64'h1;
		r = '0;
		for (int i = 0; i < NUM_TAG; i++)
			if (!r[4] && ((({8'h00, la} ^ TAG_TEXT[i]) & mask) == 64'h0) &&
				k < TAG_LEN[i] && TAG_TEXT[i][{k, 3'b000} +: 8] == c)
				r = {1'b1, (k + 3'd1 == TAG_LEN[i]), 3'(i)};
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/stt_byte_if.sv]
// Source byte channel of the tokenizer: valid/ready with byte and end marker.
// No dependencies.
`default_nettype none
interface stt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_marker;
	modport source (output valid, char_byte, end_marker, input ready);
	modport sink (input valid, char_byte, end_marker, output ready);
endinterface
`default_nettype wire

[rtl/core/stt_tok_if.sv]
// Token result channel of the tokenizer: valid/ready with the token fields.
// No dependencies.
`default_nettype none
interface stt_tok_if #(parameter int OFFSET_BITS = 20);
	logic                   valid;
	logic                   ready;
	logic [5:0]             token_type;
	logic [2:0]             status;
	logic [OFFSET_BITS-1:0] start_offset;
	logic [OFFSET_BITS-1:0] token_length;
	logic [OFFSET_BITS-1:0] line_number;
	logic                   last_of_run;
	modport source (output valid, token_type, status, start_offset, token_length,
		line_number, last_of_run, input ready);
	modport sink (input valid, token_type, status, start_offset, token_length,
		line_number, last_of_run, output ready);
endinterface
`default_nettype wire

[rtl/core/stt_front.sv]
// Front end: takes source bytes, classifies them, holds them in a two-entry queue.
// Depends on stt_pkg and stt_byte_if.
`default_nettype none
module stt_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	stt_byte_if.sink        src,
	output stt_pkg::head_t  head,
	input  wire logic       pop
);
	import stt_pkg::*;

	item_t      q0_q, q1_q, nitem;
	logic [1:0] cnt_q;
	logic       push, take;

	assign src.ready = (cnt_q != 2'd2);
	assign push      = src.valid && src.ready;
	assign take      = pop && (cnt_q != 2'd0);
	assign head      = '{valid: (cnt_q != 2'd0), item: q0_q};

	always_comb begin
		nitem.char_byte  = src.char_byte;
		nitem.end_marker = src.end_marker;
		nitem.cls        = char_class(src.char_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			if (push && !take) cnt_q <= cnt_q + 2'd1;
			else if (take && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && take) begin
			if (cnt_q == 2'd2) begin
				q0_q <= q1_q;
				q1_q <= nitem;
			end else begin
				q0_q <= nitem;
			end
		end else if (take) begin
			q0_q <= q1_q;
		end else if (push) begin
			if (cnt_q == 2'd0) q0_q <= nitem;
			else q1_q <= nitem;
		end
	end

endmodule
`default_nettype wire

[rtl/core/stt_back.sv]
// Back end: scanner state, per-byte token decisions and a four-slot result buffer.
// Depends on stt_pkg and stt_tok_if.
`default_nettype none
module stt_back #(
	parameter int OFFSET_BITS = 20
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire stt_pkg::head_t head,
	output logic            pop,
	stt_tok_if.source       tok
);
	import stt_pkg::*;

	localparam int W = OFFSET_BITS;
	localparam logic [W-1:0] OMAX = {W{1'b1}};

	function automatic logic [W-1:0] sat_inc(input logic [W-1:0] x);
		return (x == OMAX) ? x : x + W'(1);
	endfunction

	// scanner state
	mode_t        mode_q;
	logic [W-1:0] bo_q, lc_q, ts_q, tl_q;
	logic [55:0]  la_q;
	logic [63:0]  ip_q;
	logic         tlong_q, ase_q, ats_q, hal_q;

	// result buffer
	logic [5:0]   typ_q [4];
	logic [2:0]   st_q  [4];
	logic [W-1:0] so_q  [4];
	logic [W-1:0] len_q [4];
	logic [W-1:0] ln_q  [4];
	logic [2:0]   rem_q;
	logic [1:0]   idx_q;

	// next values
	mode_t        m;
	logic [W-1:0] bo, lc, ts, tl, pos, e_so, e_len;
	logic [55:0]  la;
	logic [63:0]  ip;
	logic         tlong, ase, ats, hal, cont, e_v, linc, do_put, fin;
	logic [5:0]   e_typ;
	logic [2:0]   e_st, n, k;
	logic [4:0]   tm;
	logic [7:0]   c;
	cls_t         cl;
	logic [5:0]   r_typ [4];
	logic [2:0]   r_st  [4];
	logic [W-1:0] r_so  [4];
	logic [W-1:0] r_len [4];
	logic [W-1:0] r_ln  [4];

	assign pop = head.valid && (rem_q == 3'd0 || (rem_q == 3'd1 && tok.ready));

	assign tok.valid        = (rem_q != 3'd0);
	assign tok.token_type   = typ_q[idx_q];
	assign tok.status       = st_q[idx_q];
	assign tok.start_offset = so_q[idx_q];
	assign tok.token_length = len_q[idx_q];
	assign tok.line_number  = ln_q[idx_q];
	assign tok.last_of_run  = (rem_q == 3'd1);

	always_comb begin
		m = mode_q; bo = bo_q; lc = lc_q; ts = ts_q; tl = tl_q;
		la = la_q; ip = ip_q; tlong = tlong_q; ase = ase_q; ats = ats_q; hal = hal_q;
		c = head.item.char_byte; cl = head.item.cls; fin = head.item.end_marker;
		pos = bo_q; n = 3'd0; cont = 1'b1;
		e_v = 1'b0; e_typ = TK_NONE; e_st = ST_TOKEN; e_so = '0; e_len = '0;
		linc = 1'b0; do_put = 1'b0; k = '0; tm = '0;
		for (int i = 0; i < 4; i++) begin
			r_typ[i] = TK_NONE; r_st[i] = ST_TOKEN;
			r_so[i] = '0; r_len[i] = '0; r_ln[i] = '0;
		end
		// up to three passes: a pending mode may end and hand the byte on
		for (int p = 0; p < 3; p++) begin
			e_v = 1'b0; e_typ = TK_NONE; e_st = ST_TOKEN; e_so = ts; e_len = W'(1);
			linc = 1'b0;
			k = 3'(tl - W'(1));
			tm = tag_match(k, la, c);
			if (cont && !hal) begin
				cont = 1'b0;
				if (!fin) begin
					case (m)
						MD_BLANK: begin
							if (cl == CL_NL) begin
								e_v = 1'b1; e_typ = TK_EOL; e_so = pos; linc = 1'b1;
							end else if (cl != CL_BLANK) begin
								ts = pos; tl = W'(1);
								case (cl)
									CL_SLASH: m = MD_SLASH;
									CL_MINUS: m = MD_MINUS;
									CL_DIGIT: m = MD_INT;
									CL_LT:    m = MD_LT;
									CL_GT:    m = MD_GT;
									CL_EQ:    m = MD_EQ;
									CL_COLON: begin m = MD_COLON; la = '0; end
									CL_QUOTE: begin
										ts = sat_inc(pos); tl = '0; m = MD_STRING;
									end
									CL_ALPHA: begin
										m = MD_IDENT; ip = {56'h0, c}; tlong = 1'b0;
									end
									CL_SINGLE: begin
										e_v = 1'b1; e_typ = single_code(c); e_so = pos;
									end
									default: begin
										e_v = 1'b1; e_st = ST_UNKNOWN; e_so = pos;
									end
								endcase
							end
						end
						MD_MINUS: begin
							if (cl == CL_DIGIT) begin
								tl = W'(2); m = MD_INT;
							end else begin
								e_v = 1'b1; e_typ = TK_MINUS; m = MD_BLANK; cont = 1'b1;
							end
						end
						MD_SLASH: begin
							if (c == CH_SLASH) m = MD_SLC;
							else if (c == CH_STAR) m = MD_MLC;
							else begin
								e_v = 1'b1; e_typ = TK_DIV; m = MD_BLANK; cont = 1'b1;
							end
						end
						MD_LT: begin
							e_v = 1'b1; m = MD_BLANK;
							if (c == CH_GT) begin
								e_typ = TK_NE; e_len = W'(2);
							end else if (c == CH_EQ) begin
								e_typ = TK_LE; e_len = W'(2);
							end else begin
								e_typ = TK_LT; cont = 1'b1;
							end
						end
						MD_GT: begin
							e_v = 1'b1; m = MD_BLANK;
							if (c == CH_EQ) begin
								e_typ = TK_GE; e_len = W'(2);
							end else begin
								e_typ = TK_GT; cont = 1'b1;
							end
						end
						MD_EQ: begin
							e_v = 1'b1; m = MD_BLANK;
							if (c == CH_EQ) begin
								e_typ = TK_EQ2; e_len = W'(2);
							end else begin
								e_typ = TK_ASSIGN; cont = 1'b1;
							end
						end
						MD_COLON: begin
							if (tm[4] && tm[3]) begin
								e_v = 1'b1; e_typ = TK_TAG0 + {3'b000, tm[2:0]};
								e_len = W'(k) + W'(2); m = MD_BLANK;
							end else if (tm[4]) begin
								la = la | ({48'h0, c} << {k, 3'b000});
								tl = tl + W'(1);
							end else begin
								// lone ':' and the tag letters so far rescanned as a name
								e_v = 1'b1; e_typ = TK_COLON; cont = 1'b1;
								if (k != 3'd0) begin
									m = MD_IDENT; ts = sat_inc(ts); tl = W'(k);
									ip = {8'h00, la}; tlong = 1'b0;
								end else begin
									m = MD_BLANK;
								end
							end
						end
						MD_INT: begin
							if (cl == CL_DIGIT) tl = sat_inc(tl);
							else if (c == CH_DOT) begin
								tl = sat_inc(tl); m = MD_DOT;
							end else begin
								e_v = 1'b1; e_typ = TK_INT; e_len = tl;
								m = MD_BLANK; cont = 1'b1;
							end
						end
						MD_DOT: begin
							if (cl == CL_DIGIT) begin
								tl = sat_inc(tl); m = MD_FRAC;
							end else begin
								e_v = 1'b1; e_st = ST_BADFLOAT; e_so = pos;
							end
						end
						MD_FRAC: begin
							if (cl == CL_DIGIT) tl = sat_inc(tl);
							else begin
								e_v = 1'b1; e_typ = TK_FLOAT; e_len = tl;
								m = MD_BLANK; cont = 1'b1;
							end
						end
						MD_STRING: begin
							if (c == CH_QUOTE) begin
								e_v = 1'b1; e_typ = TK_STR; e_len = tl; m = MD_BLANK;
							end else if (cl == CL_NL) begin
								e_v = 1'b1; e_st = ST_OPENSTR; e_so = pos;
							end else begin
								tl = sat_inc(tl);
							end
						end
						MD_IDENT: begin
							if (cl == CL_ALPHA || cl == CL_DIGIT) begin
								if (tl < W'(8)) ip = ip | ({56'h0, c} << {tl[2:0], 3'b000});
								else tlong = 1'b1;
								tl = sat_inc(tl);
							end else begin
								e_v = 1'b1; e_len = tl;
								e_typ = (!tlong && tl <= W'(8)) ? kw_lookup(ip) : TK_ID;
								m = MD_BLANK; cont = 1'b1;
							end
						end
						MD_SLC: begin
							if (cl == CL_NL) begin
								m = MD_BLANK; cont = 1'b1;
							end
						end
						MD_MLC, MD_MLC_STAR: begin
							if (m == MD_MLC_STAR && c == CH_SLASH) m = MD_BLANK;
							else begin
								if (cl == CL_NL) linc = 1'b1;
								m = (c == CH_STAR) ? MD_MLC_STAR : MD_MLC;
							end
						end
						default: begin
							m = MD_BLANK; cont = 1'b1;
						end
					endcase
				end else begin
					// end marker: flush whatever is pending
					case (m)
						MD_MINUS: begin e_v = 1'b1; e_typ = TK_MINUS; m = MD_BLANK; end
						MD_SLASH: begin e_v = 1'b1; e_typ = TK_DIV; m = MD_BLANK; end
						MD_LT:    begin e_v = 1'b1; e_typ = TK_LT; m = MD_BLANK; end
						MD_GT:    begin e_v = 1'b1; e_typ = TK_GT; m = MD_BLANK; end
						MD_EQ:    begin e_v = 1'b1; e_typ = TK_ASSIGN; m = MD_BLANK; end
						MD_COLON: begin
							e_v = 1'b1; e_typ = TK_COLON; m = MD_BLANK;
							if (k != 3'd0) begin
								m = MD_IDENT; ts = sat_inc(ts); tl = W'(k);
								ip = {8'h00, la}; tlong = 1'b0; cont = 1'b1;
							end
						end
						MD_INT:   begin e_v = 1'b1; e_typ = TK_INT; e_len = tl; m = MD_BLANK; end
						MD_FRAC: begin
							e_v = 1'b1; e_typ = TK_FLOAT; e_len = tl; m = MD_BLANK;
						end
						MD_IDENT: begin
							e_v = 1'b1; e_len = tl; m = MD_BLANK;
							e_typ = (!tlong && tl <= W'(8)) ? kw_lookup(ip) : TK_ID;
						end
						MD_DOT:    begin e_v = 1'b1; e_st = ST_BADFLOAT; e_so = bo; end
						MD_STRING: begin e_v = 1'b1; e_st = ST_OPENSTR; e_so = bo; end
						MD_MLC, MD_MLC_STAR: begin
							e_v = 1'b1; e_st = ST_OPENCMT; e_so = bo;
						end
						default: m = MD_BLANK;
					endcase
				end
			end
			do_put = 1'b0;
			if (e_v) begin
				if (e_st != ST_TOKEN) begin
					do_put = 1'b1; hal = 1'b1; m = MD_BLANK;
					e_typ = TK_NONE; e_len = '0;
				end else if (!(e_typ == TK_EOL && (!ats || ase))) begin
					do_put = 1'b1; ats = 1'b1;
					ase = (e_typ == TK_EOL || e_typ == TK_SEMI);
				end
			end
			if (do_put && n < 3'd4) begin
				r_typ[n[1:0]] = e_typ; r_st[n[1:0]] = e_st; r_so[n[1:0]] = e_so;
				r_len[n[1:0]] = e_len; r_ln[n[1:0]] = lc;
				n = n + 3'd1;
			end
			if (linc) lc = sat_inc(lc);
		end
		if (fin) begin
			if (!hal && !ase && n < 3'd4) begin
				r_typ[n[1:0]] = TK_EOL; r_st[n[1:0]] = ST_TOKEN; r_so[n[1:0]] = bo;
				r_len[n[1:0]] = '0; r_ln[n[1:0]] = lc;
				n = n + 3'd1;
			end
			if (n < 3'd4) begin
				r_typ[n[1:0]] = TK_END; r_st[n[1:0]] = ST_DONE; r_so[n[1:0]] = bo;
				r_len[n[1:0]] = '0; r_ln[n[1:0]] = lc;
				n = n + 3'd1;
			end
		end else begin
			bo = sat_inc(bo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MD_BLANK; bo_q <= '0; lc_q <= W'(1); ts_q <= '0; tl_q <= '0;
			la_q <= '0; ip_q <= '0; tlong_q <= 1'b0; ase_q <= 1'b0; ats_q <= 1'b0;
			hal_q <= 1'b0; rem_q <= 3'd0; idx_q <= 2'd0;
		end else begin
			if (pop) begin
				rem_q <= n; idx_q <= 2'd0;
				if (fin) begin
					mode_q <= MD_BLANK; bo_q <= '0; lc_q <= W'(1); ts_q <= '0; tl_q <= '0;
					la_q <= '0; ip_q <= '0; tlong_q <= 1'b0; ase_q <= 1'b0;
					ats_q <= 1'b0; hal_q <= 1'b0;
				end else begin
					mode_q <= m; bo_q <= bo; lc_q <= lc; ts_q <= ts; tl_q <= tl;
					la_q <= la; ip_q <= ip; tlong_q <= tlong; ase_q <= ase;
					ats_q <= ats; hal_q <= hal;
				end
			end else if (tok.valid && tok.ready) begin
				rem_q <= rem_q - 3'd1; idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < 4; i++) begin
				typ_q[i] <= r_typ[i]; st_q[i] <= r_st[i]; so_q[i] <= r_so[i];
				len_q[i] <= r_len[i]; ln_q[i] <= r_ln[i];
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/source_text_tokenizer_unit.sv]
// Top level of the source text tokenizer: front end, queue and back end.
// Depends on stt_pkg, stt_byte_if, stt_tok_if, stt_front and stt_back.
//
//   channel  dir  payload
//   src      in   char_byte, end_marker
//   tok      out  token_type, status, start_offset, token_length, line_number, last_of_run
//
// A byte is taken every cycle while the two-entry queue has room; the back end
// turns one queued byte into all of its results in a single scan and then shows them one
// per cycle while tok.ready is high.
// The result buffer is the output register; the next byte is scanned in the
// cycle its last result transfers. Reset clears the scanner to the start of a buffer.
`default_nettype none
module source_text_tokenizer_unit #(
	parameter int OFFSET_BITS = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	stt_byte_if.sink  src,
	stt_tok_if.source tok
);
	import stt_pkg::*;

	head_t head;
	logic  pop;

	stt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.head   (head),
		.pop    (pop)
	);

	stt_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.tok    (tok)
	);

endmodule
`default_nettype wire
